// ===== rtl/vcg_pkg.sv =====
// ----------------------------------------------------------------------------
// vcg_pkg
// Shared constants, codes and helper functions for the visibility gridder.
// ----------------------------------------------------------------------------
package vcg_pkg;

	localparam int MAX_GRID_SIDE = 256;
	localparam int KERNEL_TAPS   = 7;
	localparam int OVERSAMPLE    = 64;
	localparam int HALF_TAPS     = KERNEL_TAPS / 2;
	localparam int KTAB_DEPTH    = KERNEL_TAPS * OVERSAMPLE / 2 + 1;
	localparam int MIN_SIDE      = 8;
	localparam int CFRAC         = 24;
	localparam int OS_SHIFT      = CFRAC - $clog2(OVERSAMPLE);

	localparam int GIW    = $clog2(MAX_GRID_SIDE);      // row / col index bits
	localparam int GAW    = 2 * GIW;                    // grid address bits
	localparam int SIDE_W = GIW + 1;
	localparam int KIW    = $clog2(KTAB_DEPTH);
	localparam int TAPW   = $clog2(KERNEL_TAPS);
	localparam int CW     = CFRAC + GIW;                // wrapped coordinate bits
	localparam int PW     = SIDE_W + 2;                 // signed pixel bits
	localparam int DW     = CW + 5;                     // tap offset bits
	localparam int KVW    = 18;                         // kernel value bits
	localparam int TW     = 20;                         // tap weight bits
	localparam int MW     = 25;                         // multiplier operand bits
	localparam int PRW    = 2 * MW;                     // product bits
	localparam int CELL_W = 128;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_GRID  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	typedef struct packed {
		logic           ok;
		logic [KIW-1:0] idx;
	} tap_idx_t;

	typedef struct packed {
		logic           ok;
		logic [GIW-1:0] pix;
	} pix_t;

	// signed pixel of tap i around rounded coordinate r
	function automatic logic signed [PW-1:0] tap_pixel(input logic [SIDE_W-1:0] r,
			input logic [TAPW-1:0] i);
		tap_pixel = $signed({2'b00, r}) + $signed({{(PW-TAPW){1'b0}}, i})
			- PW'(HALF_TAPS);
	endfunction

	// table slot |trunc((c - p) * OVERSAMPLE)|
	function automatic tap_idx_t tap_index(input logic [CW-1:0] c,
			input logic [SIDE_W-1:0] r, input logic [TAPW-1:0] i);
		logic signed [PW-1:0] p;
		logic signed [DW-1:0] d;
		logic [DW-1:0]        ad;
		logic [DW-1:0]        g;
		p  = tap_pixel(r, i);
		d  = $signed({{(DW-CW){1'b0}}, c})
			- $signed({{(DW-PW-CFRAC){p[PW-1]}}, p, {CFRAC{1'b0}}});
		ad = d[DW-1] ? DW'(-d) : DW'(d);
		g  = ad >> OS_SHIFT;
		tap_index.ok  = (g < DW'(KTAB_DEPTH));
		tap_index.idx = g[KIW-1:0];
	endfunction

	// one wrap into the grid, then range check
	function automatic pix_t wrap_pix(input logic signed [PW-1:0] p,
			input logic [SIDE_W-1:0] side);
		logic signed [PW-1:0] s;
		logic signed [PW-1:0] w;
		s = $signed({2'b00, side});
		if (p < 0)
			w = p + s;
		else if (p >= s)
			w = p - s;
		else
			w = p;
		wrap_pix.ok  = (w >= 0) && (w < s);
		wrap_pix.pix = w[GIW-1:0];
	endfunction

	// round half up, drop 16 fraction bits
	function automatic logic signed [TW-1:0] rnd16(input logic signed [PRW-1:0] p);
		logic signed [PRW-1:0] s;
		s = p + PRW'(32768);
		rnd16 = s[TW+15:16];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [TW-1:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {{(33-TW){b[TW-1]}}, b};
		if (s > 33'sh0_7FFF_FFFF)
			sat_add = 32'sh7FFF_FFFF;
		else if (s < -33'sh0_8000_0000)
			sat_add = 32'sh8000_0000;
		else
			sat_add = s[31:0];
	endfunction

endpackage

// ===== rtl/visibility_convolutional_gridder_top.sv =====
// After reset the grids are zeroed by a sweep over all 65536 cells, during
// which no transaction is taken (configuration writes are). A grid
// visibility first forms the coordinate products and wrap, then fetches the
// seven column kernel values, then per row fetches the row value and per tap
// has the one shared multiplier do the tap weight and four part products in
// turn, with one read-modify-write per cell. One item is in work at a time;
// a new one is taken while the last result waits.
// ----------------------------------------------------------------------------
// visibility_convolutional_gridder_top
// 7x7 separable-kernel gridder of complex visibilities onto data and weight
// grids, with kernel table load and cell read / read-clear.
// ----------------------------------------------------------------------------
module visibility_convolutional_gridder_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// u_coord, v_coord, vis_re, vis_im, wgt_re, wgt_im, kernel_index,
	// kernel_value, cell_row, cell_col, 6'b0 pad
	input  logic [159:0]  s_tdata,
	// action
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// uv_re, uv_im, beam_re, beam_im
	output logic [127:0]  m_tdata,
	// status
	output logic [1:0]    m_tuser,
	input  logic          cfg_wen,
	input  logic [0:0]    cfg_addr,
	input  logic [23:0]   cfg_wdata
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_KLOAD = 5'd1;
	localparam logic [4:0] S_MUL_V = 5'd2;
	localparam logic [4:0] S_MUL_U = 5'd3;
	localparam logic [4:0] S_WRAP  = 5'd4;
	localparam logic [4:0] S_ROUND = 5'd5;
	localparam logic [4:0] S_KC_A  = 5'd6;
	localparam logic [4:0] S_KC_B  = 5'd7;
	localparam logic [4:0] S_KR_A  = 5'd8;
	localparam logic [4:0] S_KR_B  = 5'd9;
	localparam logic [4:0] S_T0    = 5'd10;
	localparam logic [4:0] S_T1    = 5'd11;
	localparam logic [4:0] S_T2    = 5'd12;
	localparam logic [4:0] S_T3    = 5'd13;
	localparam logic [4:0] S_T4    = 5'd14;
	localparam logic [4:0] S_T5    = 5'd15;
	localparam logic [4:0] S_RD_A  = 5'd16;
	localparam logic [4:0] S_RD_B  = 5'd17;
	localparam logic [4:0] S_FIN   = 5'd18;

	localparam int MW  = vcg_pkg::MW;
	localparam int PRW = vcg_pkg::PRW;
	localparam int CW  = vcg_pkg::CW;
	localparam int SW  = vcg_pkg::SIDE_W;
	localparam int LAST_TAP = vcg_pkg::KERNEL_TAPS - 1;

	logic [4:0] state_q;

	// configuration
	logic [SW-1:0] grid_side_q;
	logic [23:0]   inv_q;
	logic [SW-1:0] side;

	// latched item
	logic [1:0]               act_q;
	logic signed [23:0]       u_q, v_q;
	logic signed [15:0]       x_q [4];
	logic [7:0]               kidx_q;
	logic signed [17:0]       kval_q;
	logic [7:0]               crow_q, ccol_q;

	// gridding work registers
	logic signed [PRW-1:0]    crraw_q;
	logic [CW-1:0]            cr_q, cc_q;
	logic [SW-1:0]            rr_q, rc_q;
	logic [vcg_pkg::TAPW-1:0] mi_q, li_q;
	logic                     tok_q;
	logic signed [17:0]       kc_q [vcg_pkg::KERNEL_TAPS];
	logic signed [17:0]       kr_q;
	logic [vcg_pkg::GIW-1:0]  prow_q;
	logic                     prow_ok_q;
	logic [vcg_pkg::GAW-1:0]  gaddr_q;
	logic                     pin_q;
	logic signed [vcg_pkg::TW-1:0] t_q;
	logic signed [31:0]       cell_q [4];

	// result
	logic signed [31:0]       res_q [4];
	logic [1:0]               status_q;
	logic                     m_tvalid_q;
	logic [127:0]             m_tdata_q;
	logic [1:0]               m_tuser_q;

	// datapath wiring
	logic signed [MW-1:0]     mul_a, mul_b;
	logic signed [PRW-1:0]    prod;
	logic signed [vcg_pkg::TW-1:0] t_comb, part;
	logic [vcg_pkg::KIW-1:0]  kt_raddr;
	logic signed [17:0]       kt_rdata;
	logic                     kt_we;
	logic [vcg_pkg::GAW-1:0]  g_raddr, g_waddr;
	logic [127:0]             g_rdata, g_wdata;
	logic                     g_we, clearing;

	vcg_pkg::tap_idx_t        tix_c, tix_r;
	vcg_pkg::pix_t            pw_r, pw_c;

	logic signed [PRW-1:0]    span, cr_w, cc_w;
	logic                     coord_bad;
	logic                     cell_bad;
	logic                     s_fire;
	logic                     out_free;

	assign side = (grid_side_q < SW'(vcg_pkg::MIN_SIDE)) ? SW'(vcg_pkg::MIN_SIDE) :
		(grid_side_q > SW'(vcg_pkg::MAX_GRID_SIDE)) ? SW'(vcg_pkg::MAX_GRID_SIDE) :
		grid_side_q;

	assign s_tready = (state_q == S_IDLE) && !clearing;
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	vcg_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	vcg_ktab u_ktab (
		.clk   (clk),
		.we    (kt_we),
		.waddr (kidx_q[vcg_pkg::KIW-1:0]),
		.wdata (kval_q),
		.raddr (kt_raddr),
		.rdata (kt_rdata)
	);

	vcg_grid_mem u_grid (
		.clk      (clk),
		.arst_n   (arst_n),
		.raddr    (g_raddr),
		.rdata    (g_rdata),
		.we       (g_we),
		.waddr    (g_waddr),
		.wdata    (g_wdata),
		.clearing (clearing)
	);

	// coordinate wrap, one add of the grid span
	assign span = $signed({{(PRW-SW-vcg_pkg::CFRAC){1'b0}}, side, {vcg_pkg::CFRAC{1'b0}}});
	assign cr_w = (crraw_q < 0) ? crraw_q + span : crraw_q;
	assign cc_w = (prod < 0) ? prod + span : prod;
	assign coord_bad = (cr_w < 0) || (cr_w >= span) || (cc_w < 0) || (cc_w >= span);

	assign tix_c = vcg_pkg::tap_index(cc_q, rc_q, li_q);
	assign tix_r = vcg_pkg::tap_index(cr_q, rr_q, mi_q);
	assign pw_r  = vcg_pkg::wrap_pix(vcg_pkg::tap_pixel(rr_q, mi_q), side);
	assign pw_c  = vcg_pkg::wrap_pix(vcg_pkg::tap_pixel(rc_q, li_q), side);

	assign t_comb = vcg_pkg::rnd16(prod);
	assign part   = vcg_pkg::rnd16(prod);

	assign cell_bad = ({1'b0, crow_q} >= side) || ({1'b0, ccol_q} >= side);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL_V: begin
				mul_a = MW'(v_q);
				mul_b = $signed({1'b0, inv_q});
			end
			S_MUL_U: begin
				mul_a = MW'(u_q);
				mul_b = $signed({1'b0, inv_q});
			end
			S_T0: begin
				mul_a = MW'(kr_q);
				mul_b = MW'(kc_q[li_q]);
			end
			S_T1: begin
				mul_a = MW'(x_q[0]);
				mul_b = MW'(t_comb);
			end
			S_T2: begin
				mul_a = MW'(x_q[1]);
				mul_b = MW'(t_q);
			end
			S_T3: begin
				mul_a = MW'(x_q[2]);
				mul_b = MW'(t_q);
			end
			S_T4: begin
				mul_a = MW'(x_q[3]);
				mul_b = MW'(t_q);
			end
			default: begin
			end
		endcase
	end

	assign kt_we    = (state_q == S_KLOAD) && (kidx_q < 8'(vcg_pkg::KTAB_DEPTH));
	assign kt_raddr = (state_q == S_KR_A) ? tix_r.idx : tix_c.idx;

	assign g_raddr = (state_q == S_RD_A) ? {crow_q, ccol_q} : {prow_q, pw_c.pix};
	assign g_waddr = (state_q == S_RD_B) ? {crow_q, ccol_q} : gaddr_q;
	assign g_we    = ((state_q == S_T5) && pin_q) ||
		((state_q == S_RD_B) && (act_q == vcg_pkg::ACT_CLEAR));
	assign g_wdata = (state_q == S_RD_B) ? '0 :
		{vcg_pkg::sat_add(cell_q[3], part), cell_q[2], cell_q[1], cell_q[0]};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SW'(160);
			inv_q       <= 24'd131072;
		end else if (cfg_wen) begin
			if (cfg_addr == 1'b0)
				grid_side_q <= cfg_wdata[SW-1:0];
			else
				inv_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mi_q    <= '0;
			li_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						unique case (s_tuser)
							vcg_pkg::ACT_LOAD: state_q <= S_KLOAD;
							vcg_pkg::ACT_GRID: state_q <= S_MUL_V;
							default:           state_q <= S_RD_A;
						endcase
					end
				end
				S_KLOAD: state_q <= S_FIN;
				S_MUL_V: state_q <= S_MUL_U;
				S_MUL_U: state_q <= S_WRAP;
				S_WRAP:  state_q <= coord_bad ? S_FIN : S_ROUND;
				S_ROUND: begin
					li_q    <= '0;
					state_q <= S_KC_A;
				end
				S_KC_A: state_q <= S_KC_B;
				S_KC_B: begin
					if (li_q == LAST_TAP[vcg_pkg::TAPW-1:0]) begin
						li_q    <= '0;
						mi_q    <= '0;
						state_q <= S_KR_A;
					end else begin
						li_q    <= li_q + 1'b1;
						state_q <= S_KC_A;
					end
				end
				S_KR_A: state_q <= S_KR_B;
				S_KR_B: begin
					li_q    <= '0;
					state_q <= S_T0;
				end
				S_T0: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_T4;
				S_T4: state_q <= S_T5;
				S_T5: begin
					if (li_q != LAST_TAP[vcg_pkg::TAPW-1:0]) begin
						li_q    <= li_q + 1'b1;
						state_q <= S_T0;
					end else if (mi_q != LAST_TAP[vcg_pkg::TAPW-1:0]) begin
						mi_q    <= mi_q + 1'b1;
						state_q <= S_KR_A;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RD_A: state_q <= cell_bad ? S_FIN : S_RD_B;
				S_RD_B: state_q <= S_FIN;
				S_FIN:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q    <= s_tuser;
				u_q      <= s_tdata[23:0];
				v_q      <= s_tdata[47:24];
				x_q[0]   <= s_tdata[63:48];
				x_q[1]   <= s_tdata[79:64];
				x_q[2]   <= s_tdata[95:80];
				x_q[3]   <= s_tdata[111:96];
				kidx_q   <= s_tdata[119:112];
				kval_q   <= s_tdata[137:120];
				crow_q   <= s_tdata[145:138];
				ccol_q   <= s_tdata[153:146];
				res_q[0] <= '0;
				res_q[1] <= '0;
				res_q[2] <= '0;
				res_q[3] <= '0;
				status_q <= vcg_pkg::ST_DONE;
			end
			S_KLOAD: begin
				if (kidx_q >= 8'(vcg_pkg::KTAB_DEPTH))
					status_q <= vcg_pkg::ST_RANGE;
			end
			S_MUL_U: crraw_q <= -prod;
			S_WRAP: begin
				if (coord_bad)
					status_q <= vcg_pkg::ST_REJECT;
				cr_q <= cr_w[CW-1:0];
				cc_q <= cc_w[CW-1:0];
			end
			S_ROUND: begin
				rr_q <= SW'(({1'b0, cr_q} + (CW+1)'(1 << (vcg_pkg::CFRAC - 1)))
					>> vcg_pkg::CFRAC);
				rc_q <= SW'(({1'b0, cc_q} + (CW+1)'(1 << (vcg_pkg::CFRAC - 1)))
					>> vcg_pkg::CFRAC);
			end
			S_KC_A: tok_q <= tix_c.ok;
			S_KC_B: kc_q[li_q] <= tok_q ? kt_rdata : '0;
			S_KR_A: begin
				tok_q     <= tix_r.ok;
				prow_q    <= pw_r.pix;
				prow_ok_q <= pw_r.ok;
			end
			S_KR_B: kr_q <= tok_q ? kt_rdata : '0;
			S_T0: begin
				gaddr_q <= {prow_q, pw_c.pix};
				pin_q   <= prow_ok_q && pw_c.ok;
			end
			S_T1: begin
				t_q       <= t_comb;
				cell_q[0] <= g_rdata[31:0];
				cell_q[1] <= g_rdata[63:32];
				cell_q[2] <= g_rdata[95:64];
				cell_q[3] <= g_rdata[127:96];
			end
			S_T2: cell_q[0] <= vcg_pkg::sat_add(cell_q[0], part);
			S_T3: cell_q[1] <= vcg_pkg::sat_add(cell_q[1], part);
			S_T4: cell_q[2] <= vcg_pkg::sat_add(cell_q[2], part);
			S_RD_A: begin
				if (cell_bad)
					status_q <= vcg_pkg::ST_RANGE;
			end
			S_RD_B: begin
				res_q[0] <= g_rdata[31:0];
				res_q[1] <= g_rdata[63:32];
				res_q[2] <= g_rdata[95:64];
				res_q[3] <= g_rdata[127:96];
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if ((state_q == S_FIN) && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			m_tdata_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/vcg_mul.sv =====
// ----------------------------------------------------------------------------
// vcg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vcg_mul (
	input  logic                             clk,
	input  logic signed [vcg_pkg::MW-1:0]    a,
	input  logic signed [vcg_pkg::MW-1:0]    b,
	output logic signed [vcg_pkg::PRW-1:0]   prod
);

	logic signed [vcg_pkg::PRW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== rtl/vcg_ktab.sv =====
// ----------------------------------------------------------------------------
// vcg_ktab
// Oversampled kernel table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vcg_ktab (
	input  logic                              clk,
	input  logic                              we,
	input  logic [vcg_pkg::KIW-1:0]           waddr,
	input  logic signed [vcg_pkg::KVW-1:0]    wdata,
	input  logic [vcg_pkg::KIW-1:0]           raddr,
	output logic signed [vcg_pkg::KVW-1:0]    rdata
);

	logic signed [vcg_pkg::KVW-1:0] mem [vcg_pkg::KTAB_DEPTH];
	logic signed [vcg_pkg::KVW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/vcg_grid_mem.sv =====
// ----------------------------------------------------------------------------
// vcg_grid_mem
// Data and weight grid store, one 128-bit cell per address, with a zeroing
// sweep over every cell after reset.
// ----------------------------------------------------------------------------
module vcg_grid_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [vcg_pkg::GAW-1:0]       raddr,
	output logic [vcg_pkg::CELL_W-1:0]    rdata,
	input  logic                          we,
	input  logic [vcg_pkg::GAW-1:0]       waddr,
	input  logic [vcg_pkg::CELL_W-1:0]    wdata,
	output logic                          clearing
);

	logic [vcg_pkg::CELL_W-1:0] mem [2**vcg_pkg::GAW];
	logic [vcg_pkg::CELL_W-1:0] rdata_q;
	logic [vcg_pkg::GAW-1:0]    clr_cnt_q;
	logic                       clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q)
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_cnt_q] <= '0;
		else if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

// ===== tb/vcg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcg_checker
// Watches the input, output and configuration ports of the gridder, keeps its
// own copy of the kernel table and the uv and beam grids, predicts each
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module vcg_checker
	import vcg_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tready,
	input  logic [159:0]  s_tdata,
	input  logic [1:0]    s_tuser,
	input  logic          m_tvalid,
	input  logic          m_tready,
	input  logic [127:0]  m_tdata,
	input  logic [1:0]    m_tuser,
	input  logic          cfg_wen,
	input  logic [0:0]    cfg_addr,
	input  logic [23:0]   cfg_wdata,
	output int            errors,
	output int            pending,
	output int            results_seen,
	output int            rejects_seen
);

	typedef struct packed {
		logic [1:0]   st;
		logic [127:0] sums;
	} cell_result_t;

	cell_result_t         cell_results_q[$];
	logic [8:0]           side_reg;
	logic [23:0]          inv_reg;
	longint               ktab [KTAB_DEPTH];
	logic signed [31:0]   uv_re_g [MAX_GRID_SIDE*MAX_GRID_SIDE];
	logic signed [31:0]   uv_im_g [MAX_GRID_SIDE*MAX_GRID_SIDE];
	logic signed [31:0]   bm_re_g [MAX_GRID_SIDE*MAX_GRID_SIDE];
	logic signed [31:0]   bm_im_g [MAX_GRID_SIDE*MAX_GRID_SIDE];

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
		rejects_seen = 0;
		for (int i = 0; i < KTAB_DEPTH; i++)
			ktab[i] = 0;
		for (int i = 0; i < MAX_GRID_SIDE*MAX_GRID_SIDE; i++) begin
			uv_re_g[i] = '0;
			uv_im_g[i] = '0;
			bm_re_g[i] = '0;
			bm_im_g[i] = '0;
		end
	end

	function automatic longint side_in_use();
		longint s;
		s = longint'(side_reg);
		if (s < MIN_SIDE) s = MIN_SIDE;
		if (s > MAX_GRID_SIDE) s = MAX_GRID_SIDE;
		return s;
	endfunction

	function automatic longint round16(longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [31:0] acc32(logic signed [31:0] a, longint b);
		longint s;
		s = longint'(a) + b;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic longint kern_at(longint d);
		longint a;
		longint g;
		a = (d < 0) ? -d : d;
		g = (a * OVERSAMPLE) >>> CFRAC;
		if (g >= KTAB_DEPTH)
			return 0;
		return ktab[g];
	endfunction

	function automatic longint wrap_once(longint p, longint side);
		if (p < 0)
			return p + side;
		if (p >= side)
			return p - side;
		return p;
	endfunction

	function automatic logic [1:0] grid_visibility(longint u, longint v, longint xr,
			longint xi, longint wr, longint wi);
		longint side, span, inv, cr, cc, rr, rc, pr, pc, kr, kc, t;
		int a;
		side = side_in_use();
		span = side <<< CFRAC;
		inv  = longint'(inv_reg);
		cr   = -(v * inv);
		cc   = u * inv;
		if (cr < 0) cr += span;
		if (cc < 0) cc += span;
		if (cr < 0 || cr >= span || cc < 0 || cc >= span)
			return ST_REJECT;
		rr = (cr + 64'sd8388608) >>> CFRAC;
		rc = (cc + 64'sd8388608) >>> CFRAC;
		for (int m = -HALF_TAPS; m <= HALF_TAPS; m++) begin
			pr = rr + m;
			kr = kern_at(cr - (pr <<< CFRAC));
			pr = wrap_once(pr, side);
			for (int l = -HALF_TAPS; l <= HALF_TAPS; l++) begin
				pc = rc + l;
				kc = kern_at(cc - (pc <<< CFRAC));
				t  = round16(kr * kc);
				pc = wrap_once(pc, side);
				if (pr < 0 || pr >= side || pc < 0 || pc >= side)
					continue;
				a = int'(pr * MAX_GRID_SIDE + pc);
				uv_re_g[a] = acc32(uv_re_g[a], round16(xr * t));
				uv_im_g[a] = acc32(uv_im_g[a], round16(xi * t));
				bm_re_g[a] = acc32(bm_re_g[a], round16(wr * t));
				bm_im_g[a] = acc32(bm_im_g[a], round16(wi * t));
			end
		end
		return ST_DONE;
	endfunction

	function automatic cell_result_t predict_cell(logic [1:0] act, logic [159:0] d);
		cell_result_t r;
		longint side;
		int a;
		r = '0;
		r.st = ST_DONE;
		case (act)
			ACT_LOAD: begin
				if (d[119:112] >= KTAB_DEPTH)
					r.st = ST_RANGE;
				else
					ktab[d[119:112]] = longint'($signed(d[137:120]));
			end
			ACT_GRID: begin
				r.st = grid_visibility(longint'($signed(d[23:0])),
					longint'($signed(d[47:24])), longint'($signed(d[63:48])),
					longint'($signed(d[79:64])), longint'($signed(d[95:80])),
					longint'($signed(d[111:96])));
			end
			default: begin
				side = side_in_use();
				if (d[145:138] >= side || d[153:146] >= side) begin
					r.st = ST_RANGE;
				end else begin
					a = int'(d[145:138]) * MAX_GRID_SIDE + int'(d[153:146]);
					r.sums = {bm_im_g[a], bm_re_g[a], uv_im_g[a], uv_re_g[a]};
					if (act == ACT_CLEAR) begin
						uv_re_g[a] = '0;
						uv_im_g[a] = '0;
						bm_re_g[a] = '0;
						bm_im_g[a] = '0;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic void report(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			side_reg <= 9'd160;
			inv_reg  <= 24'd131072;
		end else begin
			if (cfg_wen) begin
				if (cfg_addr == 1'b0)
					side_reg <= cfg_wdata[8:0];
				else
					inv_reg <= cfg_wdata;
			end
			if (s_tvalid && s_tready)
				cell_results_q.push_back(predict_cell(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tuser == ST_REJECT)
					rejects_seen++;
				if (cell_results_q.size() == 0) begin
					report("unexpected transaction", '0, m_tdata[31:0]);
				end else begin
					want = cell_results_q.pop_front();
					if (m_tuser != want.st)
						report("status", 32'(want.st), 32'(m_tuser));
					if (m_tdata[31:0] != want.sums[31:0])
						report("uv_re", want.sums[31:0], m_tdata[31:0]);
					if (m_tdata[63:32] != want.sums[63:32])
						report("uv_im", want.sums[63:32], m_tdata[63:32]);
					if (m_tdata[95:64] != want.sums[95:64])
						report("beam_re", want.sums[95:64], m_tdata[95:64]);
					if (m_tdata[127:96] != want.sums[127:96])
						report("beam_im", want.sums[127:96], m_tdata[127:96]);
				end
			end
			pending <= cell_results_q.size();
		end
	end

endmodule

// ===== tb/tb_visibility_convolutional_gridder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_visibility_convolutional_gridder_top
// Loads the kernel table, runs directed and random load / grid / read / clear
// traffic over several grid sizes and uv resolutions, with random stalls on
// both stream sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_visibility_convolutional_gridder_top;
	import vcg_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 340;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [159:0]  s_tdata = '0;
	logic [1:0]    s_tuser = ACT_LOAD;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [127:0]  m_tdata;
	logic [1:0]    m_tuser;
	logic          cfg_wen = 1'b0;
	logic [0:0]    cfg_addr = 1'b0;
	logic [23:0]   cfg_wdata = '0;

	int            errors, pending, results_seen, rejects_seen;
	int            n_load, n_grid, n_read, n_clear, n_settings;
	bit            no_idle = 1'b0;
	bit            hold_req = 1'b0;
	int            hold_left = 0;
	int            quiet_cycles = 0;
	longint        cur_side = 160;
	longint        cur_inv = 131072;

	visibility_convolutional_gridder_top uut (.*);

	vcg_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random back-pressure, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (no_idle) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 28);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send(logic [1:0] act, int u, int v, int vr, int vi, int wr, int wi,
			int kidx, int kval, int row, int col);
		if (!no_idle)
			while ($urandom_range(0, 99) < 28) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {6'b0, col[7:0], row[7:0], kval[17:0], kidx[7:0], wi[15:0], wr[15:0],
			vi[15:0], vr[15:0], v[23:0], u[23:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (act)
			ACT_LOAD: n_load++;
			ACT_GRID: n_grid++;
			ACT_READ: n_read++;
			default:  n_clear++;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_grid(int side, int inv);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_addr  <= 1'b0;
		cfg_wdata <= 24'(side);
		@(posedge clk);
		cfg_addr  <= 1'b1;
		cfg_wdata <= 24'(inv);
		@(posedge clk);
		cfg_wen   <= 1'b0;
		cur_side = (side < MIN_SIDE) ? MIN_SIDE : (side > MAX_GRID_SIDE) ? MAX_GRID_SIDE : side;
		cur_inv = inv;
		n_settings++;
	endtask

	function automatic int coord_in_grid();
		longint lim;
		lim = (cur_side <<< CFRAC) / cur_inv;
		if (lim > 8388607) lim = 8388607;
		return int'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
	endfunction

	function automatic int cell_index();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, int'(cur_side) - 1);
		return $urandom_range(0, 255);
	endfunction

	task automatic random_item(bit in_grid);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			send(ACT_LOAD, 0, 0, 0, 0, 0, 0, $urandom_range(0, 255),
				$urandom_range(0, 262143), 0, 0);
		else if (r < 45)
			send(ACT_GRID,
				in_grid ? coord_in_grid() : int'($urandom_range(0, 24'hFFFFFF)),
				in_grid ? coord_in_grid() : int'($urandom_range(0, 24'hFFFFFF)),
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0, 0, 0);
		else
			send((r < 80) ? ACT_READ : ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
				cell_index(), cell_index());
	endtask

	initial begin
		int sides [6];
		int invs [6];
		sides = '{160, 8, 256, 16, 300, 5};
		invs  = '{131072, 16777215, 1, 1048576, 196608, 400000};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_grid(160, 131072);

		// kernel table: full-scale ends, falling ramp between
		for (int i = 0; i < KTAB_DEPTH; i++)
			send(ACT_LOAD, 0, 0, 0, 0, 0, 0, i,
				(i == 0) ? 131071 : (i == KTAB_DEPTH - 1) ? -131072
				: 65536 * (KTAB_DEPTH - 1 - i) / (KTAB_DEPTH - 1), 0, 0);

		// directed: slot out of range, cell reads at edges and beyond,
		// coordinate wrap, rejects, field extremes, read and clear
		send(ACT_LOAD, 0, 0, 0, 0, 0, 0, KTAB_DEPTH, 5, 0, 0);
		send(ACT_LOAD, 0, 0, 0, 0, 0, 0, 255, 5, 0, 0);
		send(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(ACT_GRID, 0, 0, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
		send(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 159, 159);
		send(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		send(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		send(ACT_GRID, -256, 256, 21845, -21846, 12345, -1, 0, 0, 0, 0);
		send(ACT_GRID, 200, -77, -32768, 32767, 32767, -32768, 0, 0, 0, 0);
		send(ACT_GRID, 8388607, 0, 1, 1, 1, 1, 0, 0, 0, 0);
		send(ACT_GRID, 0, -8388608, 1, 1, 1, 1, 0, 0, 0, 0);
		send(ACT_GRID, -8388608, 8388607, -1, -1, -1, -1, 0, 0, 0, 0);
		send(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 255, 0);
		send(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 200);
		send(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 158, 2);
		send(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 158, 2);

		for (int ph = 0; ph < 6; ph++) begin
			set_grid(sides[ph], invs[ph]);
			for (int n = 0; n < 270; n++) begin
				no_idle = (ph == 1 && n >= 100 && n < 200);
				if (ph == 2 && n == 50)
					hold_req = 1'b1;
				if (ph == 3 && n == 100)
					drain();
				random_item($urandom_range(0, 99) < 90);
			end
		end
		no_idle = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d kernel loads, %0d visibilities, %0d reads, %0d read-clears",
			n_load, n_grid, n_read, n_clear);
		$display("over %0d grid settings; %0d results checked, %0d rejected coordinates",
			n_settings, results_seen, rejects_seen);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
